// ===== src/trr_pkg.sv =====
// Shared constants, codes and state type for the tile residency and replacement block.
package trr_pkg;

  localparam int unsigned NUM_TILES_DEF   = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned STEP_BITS_DEF   = 32;

  localparam int unsigned ORDER_W     = 32;
  localparam int unsigned POL_W       = 2;
  localparam int unsigned TE_W        = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned STEP_OUT_W  = 32;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned TILE_OUT_W  = 4;
  localparam int unsigned EVICT_OUT_W = 16;

  localparam logic [POL_W-1:0] POL_BELADY = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU    = 2'd1;
  localparam logic [POL_W-1:0] POL_FIFO   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_REUSE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PROGRAM = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EVICT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES  = 1'd1;

  localparam logic [TE_W-1:0] TILES_RESET = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

endpackage

// ===== src/trr_store.sv =====
// Per-tile storage: weight, next use, last use and program order, one read and one write port.
module trr_store import trr_pkg::*; #(
  parameter int unsigned NUM_TILES   = NUM_TILES_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int unsigned STEP_BITS   = STEP_BITS_DEF,
  localparam int unsigned IDX_W      = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [IDX_W-1:0]       rd_addr_i,
  output logic [WEIGHT_BITS-1:0] rd_weight_o,
  output logic [STEP_BITS-1:0]   rd_next_o,
  output logic [STEP_BITS-1:0]   rd_last_o,
  output logic [ORDER_W-1:0]     rd_order_o,
  input  logic                   wr_en_i,
  input  logic                   wr_prog_i,
  input  logic [IDX_W-1:0]       wr_addr_i,
  input  logic [WEIGHT_BITS-1:0] wr_weight_i,
  input  logic [STEP_BITS-1:0]   wr_next_i,
  input  logic [STEP_BITS-1:0]   wr_last_i,
  input  logic [ORDER_W-1:0]     wr_order_i
);

  logic [WEIGHT_BITS-1:0] weight_mem [NUM_TILES];
  logic [STEP_BITS-1:0]   next_mem   [NUM_TILES];
  logic [STEP_BITS-1:0]   last_mem   [NUM_TILES];
  logic [ORDER_W-1:0]     order_mem  [NUM_TILES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      next_mem[wr_addr_i] <= wr_next_i;
      last_mem[wr_addr_i] <= wr_last_i;
      if (wr_prog_i) begin
        weight_mem[wr_addr_i] <= wr_weight_i;
        order_mem[wr_addr_i]  <= wr_order_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_weight_o <= weight_mem[rd_addr_i];
      rd_next_o   <= next_mem[rd_addr_i];
      rd_last_o   <= last_mem[rd_addr_i];
      rd_order_o  <= order_mem[rd_addr_i];
    end
  end

endmodule

// ===== src/trr_cmp.sv =====
// Shared compare unit: weight match and policy-ranked victim compare for one tile entry.
module trr_cmp import trr_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int unsigned STEP_BITS   = STEP_BITS_DEF,
  localparam int unsigned KEY_W      = (STEP_BITS > ORDER_W) ? STEP_BITS : ORDER_W
) (
  input  logic [POL_W-1:0]       policy_i,
  input  logic [WEIGHT_BITS-1:0] want_weight_i,
  input  logic [WEIGHT_BITS-1:0] ent_weight_i,
  input  logic [STEP_BITS-1:0]   ent_next_i,
  input  logic [STEP_BITS-1:0]   ent_last_i,
  input  logic [ORDER_W-1:0]     ent_order_i,
  input  logic [KEY_W-1:0]       best_key_i,
  output logic                   match_o,
  output logic [KEY_W-1:0]       key_o,
  output logic                   better_o
);

  // Every policy is reduced to "smaller key wins"; the furthest next use inverts its key.
  always_comb begin
    unique case (policy_i)
      POL_LRU:  key_o = KEY_W'(ent_last_i);
      POL_FIFO: key_o = KEY_W'(ent_order_i);
      default:  key_o = ~KEY_W'(ent_next_i);
    endcase
  end

  assign match_o  = (ent_weight_i == want_weight_i);
  assign better_o = (key_o < best_key_i);

endmodule

// ===== src/tile_residency_replacement.sv =====
// Top level: sequencer, counters and result registers of the tile residency and replacement block.
//
// Usage: drive weight_id_i and next_use_step_i and raise start while busy is low; the beat
// is taken at that clock edge and busy rises on the next cycle. The block then walks the
// occupied tiles through one shared compare unit, one tile per cycle, looking for the weight
// and ranking eviction candidates in the same pass. A drain state and an update state
// follow; scan and drain are skipped when no tile is occupied. The pass over the tile
// store's single read port sets how long busy stays high. After the update state the
// result beat is registered and appears on step_index_o, action_o, tile_index_o and
// evicted_weight_o for exactly one cycle with done_o high, and that cycle is also the
// first one in which a new beat may be started, so a new beat is never taken before the
// last one is done. The receiver cannot stall.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while busy is low:
// index 0 selects the victim policy, index 1 the number of usable tiles.
// Reset empties all tiles, zeroes the step and program counters, selects the furthest next
// use policy and enables sixteen tiles. Tile contents are not cleared.
module tile_residency_replacement import trr_pkg::*; #(
  parameter int unsigned NUM_TILES   = NUM_TILES_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int unsigned STEP_BITS   = STEP_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   start,
  output logic                   busy,
  input  logic [WEIGHT_BITS-1:0] weight_id_i,
  input  logic [STEP_BITS-1:0]   next_use_step_i,
  output logic                   done_o,
  output logic [STEP_OUT_W-1:0]  step_index_o,
  output logic [ACT_W-1:0]       action_o,
  output logic [TILE_OUT_W-1:0]  tile_index_o,
  output logic [EVICT_OUT_W-1:0] evicted_weight_o
);

  localparam int unsigned IDX_W = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TILES + 1);
  localparam int unsigned KEY_W = (STEP_BITS > ORDER_W) ? STEP_BITS : ORDER_W;

  state_e                 state_q, state_d;
  logic [POL_W-1:0]       policy_q;
  logic [TE_W-1:0]        tiles_en_q;
  logic [CNT_W-1:0]       in_use_q, in_use_d;
  logic [ORDER_W-1:0]     prog_cnt_q, prog_cnt_d;
  logic [STEP_BITS-1:0]   step_cnt_q, step_cnt_d;
  logic                   pv_q, pv_d;
  logic                   hit_q, hit_d;
  logic                   done_q, done_d;

  logic [WEIGHT_BITS-1:0] w_q;
  logic [STEP_BITS-1:0]   nu_q;
  logic [IDX_W-1:0]       ptr_q, ptr_d;
  logic [IDX_W-1:0]       pidx_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [KEY_W-1:0]       best_key_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [WEIGHT_BITS-1:0] best_w_q;
  logic [STEP_OUT_W-1:0]  step_out_q;
  logic [ACT_W-1:0]       act_out_q;
  logic [TILE_OUT_W-1:0]  tile_out_q;
  logic [EVICT_OUT_W-1:0] evict_out_q;

  logic                   accept;
  logic [CNT_W-1:0]       limit;
  logic                   rd_en;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [STEP_BITS-1:0]   rd_next;
  logic [STEP_BITS-1:0]   rd_last;
  logic [ORDER_W-1:0]     rd_order;
  logic                   wr_en;
  logic                   prog;
  logic [ACT_W-1:0]       act;
  logic [IDX_W-1:0]       tile_sel;
  logic                   match;
  logic [KEY_W-1:0]       ent_key;
  logic                   better;
  logic                   cand;

  logic [STEP_BITS+STEP_OUT_W-1:0]   step_ext;
  logic [IDX_W+TILE_OUT_W-1:0]       tile_ext;
  logic [WEIGHT_BITS+EVICT_OUT_W-1:0] evict_ext;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    priority if (tiles_en_q == '0) begin
      limit = CNT_W'(1);
    end else if (32'(tiles_en_q) > 32'(NUM_TILES)) begin
      limit = CNT_W'(NUM_TILES);
    end else begin
      limit = CNT_W'(tiles_en_q);
    end
  end

  trr_store #(
    .NUM_TILES  (NUM_TILES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (ptr_q),
    .rd_weight_o(rd_weight),
    .rd_next_o  (rd_next),
    .rd_last_o  (rd_last),
    .rd_order_o (rd_order),
    .wr_en_i    (wr_en),
    .wr_prog_i  (prog),
    .wr_addr_i  (tile_sel),
    .wr_weight_i(w_q),
    .wr_next_i  (nu_q),
    .wr_last_i  (step_cnt_q),
    .wr_order_i (prog_cnt_q)
  );

  trr_cmp #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_cmp (
    .policy_i     (policy_q),
    .want_weight_i(w_q),
    .ent_weight_i (rd_weight),
    .ent_next_i   (rd_next),
    .ent_last_i   (rd_last),
    .ent_order_i  (rd_order),
    .best_key_i   (best_key_q),
    .match_o      (match),
    .key_o        (ent_key),
    .better_o     (better)
  );

  // Victims are ranked only among tiles below the enabled limit.
  assign cand = (CNT_W'(pidx_q) < limit);

  always_comb begin
    priority if (hit_q) begin
      act      = ACT_REUSE;
      tile_sel = hit_idx_q;
      prog     = 1'b0;
    end else if (in_use_q < limit) begin
      act      = ACT_PROGRAM;
      tile_sel = IDX_W'(in_use_q);
      prog     = 1'b1;
    end else begin
      act      = ACT_EVICT;
      tile_sel = best_idx_q;
      prog     = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    in_use_d   = in_use_q;
    prog_cnt_d = prog_cnt_q;
    step_cnt_d = step_cnt_q;
    pv_d       = 1'b0;
    done_d     = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    hit_d      = hit_q || (pv_q && match);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ptr_d   = '0;
          hit_d   = 1'b0;
          state_d = (in_use_q == '0) ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        pv_d  = 1'b1;
        ptr_d = ptr_q + IDX_W'(1);
        if (CNT_W'(ptr_q) + CNT_W'(1) == in_use_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        wr_en  = 1'b1;
        done_d = 1'b1;
        if (act == ACT_PROGRAM) begin
          in_use_d = in_use_q + CNT_W'(1);
        end
        if (prog && (prog_cnt_q != '1)) begin
          prog_cnt_d = prog_cnt_q + ORDER_W'(1);
        end
        if (step_cnt_q != '1) begin
          step_cnt_d = step_cnt_q + STEP_BITS'(1);
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      policy_q   <= POL_BELADY;
      tiles_en_q <= TILES_RESET;
      in_use_q   <= '0;
      prog_cnt_q <= '0;
      step_cnt_q <= '0;
      pv_q       <= 1'b0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_use_q   <= in_use_d;
      prog_cnt_q <= prog_cnt_d;
      step_cnt_q <= step_cnt_d;
      pv_q       <= pv_d;
      hit_q      <= hit_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLICY: policy_q   <= cfg_data_i[POL_W-1:0];
          CFG_TILES:  tiles_en_q <= cfg_data_i[TE_W-1:0];
          default:    tiles_en_q <= tiles_en_q;
        endcase
      end
    end
  end

  assign step_ext  = {{STEP_OUT_W{1'b0}}, step_cnt_q};
  assign tile_ext  = {{TILE_OUT_W{1'b0}}, tile_sel};
  assign evict_ext = {{EVICT_OUT_W{1'b0}}, best_w_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q  <= weight_id_i;
      nu_q <= next_use_step_i;
    end
    ptr_q  <= ptr_d;
    pidx_q <= ptr_q;
    if (pv_q && !hit_q && match) begin
      hit_idx_q <= pidx_q;
    end
    if (pv_q && cand && ((pidx_q == '0) || better)) begin
      best_key_q <= ent_key;
      best_idx_q <= pidx_q;
      best_w_q   <= rd_weight;
    end
    if (state_q == ST_UPDATE) begin
      step_out_q  <= step_ext[STEP_OUT_W-1:0];
      act_out_q   <= act;
      tile_out_q  <= tile_ext[TILE_OUT_W-1:0];
      evict_out_q <= (act == ACT_EVICT) ? evict_ext[EVICT_OUT_W-1:0] : '0;
    end
  end

  assign done_o           = done_q;
  assign step_index_o     = step_out_q;
  assign action_o         = act_out_q;
  assign tile_index_o     = tile_out_q;
  assign evicted_weight_o = evict_out_q;

endmodule
